// ===== rtl/jmdc_pkg.sv =====
package jmdc_pkg;

	// Default sizes of the sample store.
	localparam int DefChannels = 8;
	localparam int DefWindow   = 5;

	// Field widths.
	localparam int ChW     = 3;
	localparam int SmpW    = 12;
	localparam int BandW   = 11;
	localparam int AxisW   = 13;

	// Converter midpoint and output full scale.
	localparam logic [SmpW-1:0] Midpoint = 12'd2048;
	localparam int FullShift = 11;

	// Quotient bits of the cubic divide (the quotient never exceeds 2048).
	localparam int QW   = 12;
	localparam int CubW = 34;
	localparam int RemW = CubW + FullShift + 1;

endpackage

// ===== rtl/jmdc_window.sv =====
module jmdc_window #(
	parameter int CHANNELS = jmdc_pkg::DefChannels,
	parameter int WINDOW   = jmdc_pkg::DefWindow,
	parameter int AW       = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [AW-1:0]              slot,
	input  logic [jmdc_pkg::SmpW-1:0]  sample,
	output logic                       med_valid,
	output logic [jmdc_pkg::SmpW-1:0]  median
);
	import jmdc_pkg::*;

	localparam int RowW = WINDOW * SmpW;
	localparam int CW   = $clog2(WINDOW + 1);

	logic [RowW-1:0]     mem [CHANNELS];
	logic [RowW-1:0]     rd_data_q;
	logic [CHANNELS-1:0] row_valid_q;
	logic [AW-1:0]       slot_q;
	logic [SmpW-1:0]     sample_q;
	logic                pend_q;
	logic                med_valid_q;
	logic [SmpW-1:0]     median_s2;
	logic [RowW-1:0]     old_row;
	logic [RowW-1:0]     new_row;
	logic [SmpW-1:0]     med_c;
	logic [CW-1:0]       rank;

	// Each row is read once per transaction and written back in the next cycle,
	// before another transaction can start, so reads never see a stale row.
	always_ff @(posedge clk) begin
		if (start) begin
			rd_data_q <= mem[slot];
			slot_q    <= slot;
			sample_q  <= sample;
		end
		if (pend_q) begin
			mem[slot_q] <= new_row;
			median_s2   <= med_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			med_valid_q <= 1'b0;
			row_valid_q <= '0;
		end else begin
			pend_q      <= start;
			med_valid_q <= pend_q;
			if (pend_q) begin
				row_valid_q[slot_q] <= 1'b1;
			end
		end
	end

	// A row never written reads as all zero; shift the new sample in at the top.
	always_comb begin
		old_row = row_valid_q[slot_q] ? rd_data_q : '0;
		new_row = {sample_q, old_row[RowW-1:SmpW]};
	end

	// Median by rank: ties are ordered by position, so exactly one entry
	// holds the middle rank.
	always_comb begin
		med_c = '0;
		for (int i = 0; i < WINDOW; i++) begin
			rank = '0;
			for (int j = 0; j < WINDOW; j++) begin
				if (j != i) begin
					if ((new_row[j*SmpW +: SmpW] < new_row[i*SmpW +: SmpW]) ||
					    ((new_row[j*SmpW +: SmpW] == new_row[i*SmpW +: SmpW]) && (j < i))) begin
						rank = rank + 1'b1;
					end
				end
			end
			if (rank == CW'(WINDOW / 2)) begin
				med_c = new_row[i*SmpW +: SmpW];
			end
		end
	end

	assign med_valid = med_valid_q;
	assign median    = median_s2;

endmodule

// ===== rtl/jmdc_cubic.sv =====
module jmdc_cubic (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [jmdc_pkg::SmpW-1:0]   median,
	input  logic [jmdc_pkg::BandW-1:0]  dead_band,
	input  logic                        ack,
	output logic                        done,
	output logic signed [jmdc_pkg::AxisW-1:0] value
);
	import jmdc_pkg::*;

	typedef enum logic [4:0] {
		C_IDLE = 5'b00001,
		C_SQ   = 5'b00010,
		C_CUBE = 5'b00100,
		C_DIV  = 5'b01000,
		C_DONE = 5'b10000
	} cstate_t;

	cstate_t          state_q;
	logic [3:0]       k_q;
	logic [SmpW-1:0]  mag_q;
	logic [SmpW-1:0]  m_q;
	logic             neg_q;
	logic [2*SmpW-1:0] mag2_q;
	logic [2*SmpW-1:0] m2_q;
	logic [RemW-1:0]  rem_q;
	logic [RemW-1:0]  dsh_q;
	logic [QW-1:0]    q_q;
	logic [SmpW-1:0]  upper;
	logic [SmpW-1:0]  lower;
	logic [3*SmpW-1:0] mag3;
	logic [3*SmpW-1:0] m3;
	logic             fits;

	// Band edges, cube products and the divide compare; the lower edge is also the span m of the curve.
	always_comb begin
		upper = Midpoint + {1'b0, dead_band};
		lower = Midpoint - {1'b0, dead_band};
		mag3  = mag2_q * {{(2*SmpW){1'b0}}, mag_q};
		m3    = m2_q * {{(2*SmpW){1'b0}}, m_q};
		fits  = rem_q >= dsh_q;
	end

	// Sequencer: offset, squares, cubes, then one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: if (start) state_q <= C_SQ;
				C_SQ:   state_q <= C_CUBE;
				C_CUBE: begin
					state_q <= C_DIV;
					k_q     <= 4'(QW - 1);
				end
				C_DIV: begin
					if (k_q == '0) state_q <= C_DONE;
					k_q <= k_q - 1'b1;
				end
				C_DONE: if (ack) state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			m_q <= lower;
			if (median >= upper) begin
				mag_q <= median - upper;
				neg_q <= 1'b1;
			end else if (median <= lower) begin
				mag_q <= lower - median;
				neg_q <= 1'b0;
			end else begin
				mag_q <= '0;
				neg_q <= 1'b0;
			end
		end
		if (state_q == C_SQ) begin
			mag2_q <= mag_q * mag_q;
			m2_q   <= m_q * m_q;
		end
		if (state_q == C_CUBE) begin
			rem_q <= {1'b0, mag3[CubW-1:0], {FullShift{1'b0}}};
			dsh_q <= {1'b0, m3[CubW-1:0], {FullShift{1'b0}}};
			q_q   <= '0;
		end
		if (state_q == C_DIV) begin
			if (fits) rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			q_q   <= {q_q[QW-2:0], fits};
		end
	end

	assign done  = (state_q == C_DONE);
	assign value = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

endmodule

// ===== rtl/joystick_median_deadband_cubic.sv =====
// Channel  Handshake          Payload
// in       in_valid/in_stall  channel, sample
// out      out_valid/out_stall out_channel, axis_value
// cfg      cfg_wr_en          cfg_wr_data (dead band)
//
// A transaction passes the window read, write-back and median, then the offset,
// square, cube and bit-serial divide states of the cubic curve, into the output
// register; the next one is taken in the cycle after that load.
// The input stalls while a transaction is in flight; the next one is taken
// as soon as the result sits in the output register, even if it waits there.
// Reset clears the window valid bits, so every window reads as zeros.
module joystick_median_deadband_cubic #(
	parameter int CHANNELS = jmdc_pkg::DefChannels,
	parameter int WINDOW   = jmdc_pkg::DefWindow
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [jmdc_pkg::ChW-1:0]          channel,
	input  logic [jmdc_pkg::SmpW-1:0]         sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [jmdc_pkg::ChW-1:0]          out_channel,
	output logic signed [jmdc_pkg::AxisW-1:0] axis_value,
	input  logic                              cfg_wr_en,
	input  logic [jmdc_pkg::BandW-1:0]        cfg_wr_data
);
	import jmdc_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic              busy_q;
	logic              out_valid_q;
	logic [ChW-1:0]    ch_q;
	logic [ChW-1:0]    out_channel_q;
	logic signed [AxisW-1:0] axis_q;
	logic [BandW-1:0]  dead_band_q;
	logic              accept;
	logic              load;
	logic [4:0]        fold;
	logic [AW-1:0]     slot;
	logic              med_valid;
	logic [SmpW-1:0]   median;
	logic              res_done;
	logic signed [AxisW-1:0] res_value;

	assign accept = in_valid && !busy_q;
	assign load   = res_done && (!out_valid_q || !out_stall);

	// Fold the channel into the window range by repeated subtraction.
	always_comb begin
		fold = {2'b00, channel};
		for (int i = 0; i < 8; i++) begin
			if (fold >= 5'(CHANNELS)) fold = fold - 5'(CHANNELS);
		end
		slot = fold[AW-1:0];
	end

	jmdc_window #(.CHANNELS(CHANNELS), .WINDOW(WINDOW), .AW(AW)) u_window (
		.clk(clk), .arst_n(arst_n), .start(accept), .slot(slot), .sample(sample),
		.med_valid(med_valid), .median(median)
	);

	jmdc_cubic u_cubic (
		.clk(clk), .arst_n(arst_n), .start(med_valid), .median(median),
		.dead_band(dead_band_q), .ack(load), .done(res_done), .value(res_value)
	);

	// Control: busy from accept until the result moves to the output register; also output valid and the dead band.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			dead_band_q <= '0;
		end else begin
			if (cfg_wr_en) dead_band_q <= cfg_wr_data;
			if (accept) busy_q <= 1'b1;
			else if (load) busy_q <= 1'b0;
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) ch_q <= channel;
		if (load) begin
			out_channel_q <= ch_q;
			axis_q        <= res_value;
		end
	end

	assign in_stall    = busy_q;
	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign axis_value  = axis_q;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_done |-> busy_q) else $error("result without transaction");
	a_med_busy: assert property (@(posedge clk) disable iff (!arst_n)
		med_valid |-> busy_q && !res_done) else $error("median outside transaction");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q && !busy_q) else $error("output load lost");

endmodule
